[sv/lapic_pkg.sv]
// ----------------------------------------------------------------------------
// lapic_pkg
// Shared types and constants of the local APIC timer core.
// ----------------------------------------------------------------------------
package lapic_pkg;

    localparam int COUNT_WIDTH     = 32;
    localparam int MAX_DIVIDE_LOG2 = 7;
    localparam int PRESC_WIDTH     = MAX_DIVIDE_LOG2;
    localparam int PERIOD_WIDTH    = MAX_DIVIDE_LOG2 + 1;

    localparam logic [31:0] LVT_MASK_BIT  = 32'h0001_0000;
    localparam int          LVT_MODE_LSB  = 17;
    localparam logic [3:0]  DIV_KEEP_BITS = 4'b1011;
    localparam logic [1:0]  MODE_PERIODIC = 2'd1;
    localparam logic [2:0]  DIV_CODE_ONE  = 3'd7;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } lapic_req_type_t;

    typedef enum logic [2:0] {
        SEL_LVT        = 3'd0,
        SEL_INIT_COUNT = 3'd1,
        SEL_CUR_COUNT  = 3'd2,
        SEL_DIVIDE     = 3'd3,
        SEL_EOI        = 3'd4
    } lapic_sel_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
    } lapic_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_fire;
        logic [7:0]  irq_vector;
        logic        in_service;
    } lapic_rsp_t;

    // Prescaler period, 2^log2 with the exponent capped.
    function automatic logic [PERIOD_WIDTH-1:0] divide_period(input logic [3:0] code);
        logic [2:0] c;
        logic [3:0] l;
        c = {code[3], code[1:0]};
        l = (c == DIV_CODE_ONE) ? 4'd0 : {1'b0, c} + 4'd1;
        if (l > 4'(MAX_DIVIDE_LOG2)) begin
            l = 4'(MAX_DIVIDE_LOG2);
        end
        return PERIOD_WIDTH'(1) << l;
    endfunction

endpackage

[sv/local_apic_timer_core.sv]
// ----------------------------------------------------------------------------
// local_apic_timer_core
// Local APIC timer: register reads/writes and timer ticks in, one response
// out per request.
//
//   channel   direction  ports
//   request   in         s_valid s_ready s_req_type s_reg_select s_write_data
//   response  out        m_valid m_ready m_read_data m_irq_fire m_irq_vector
//                        m_in_service
//
// One request per cycle while m_ready does not stall; a response is presented
// once its request has passed the input register, then the response register.
// Timer state commits when a request moves from the input register to the
// response register, so requests act strictly in order.
// Reset (aresetn low, synchronous) empties both registers and restores the
// timer state: entry masked, one-shot, divide by two, countdown stopped.
// A stalled m_ready holds the response; s_ready drops only when both
// registers are full.
// ----------------------------------------------------------------------------
module local_apic_timer_core
    import lapic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [2:0]  s_reg_select,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_fire,
    output logic [7:0]  m_irq_vector,
    output logic        m_in_service
);

    lapic_req_t s_req;
    lapic_req_t req;
    lapic_rsp_t rsp;
    lapic_rsp_t m_rsp;
    logic       req_valid;
    logic       rsp_ready;
    logic       advance;

    assign s_req.req_type   = s_req_type;
    assign s_req.reg_select = s_reg_select;
    assign s_req.write_data = s_write_data;

    assign advance = req_valid && rsp_ready;

    lapic_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    lapic_timer_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req),
        .rsp     (rsp)
    );

    lapic_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rsp_valid (req_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp)
    );

    assign m_read_data  = m_rsp.read_data;
    assign m_irq_fire   = m_rsp.irq_fire;
    assign m_irq_vector = m_rsp.irq_vector;
    assign m_in_service = m_rsp.in_service;

endmodule

[sv/lapic_in_stage.sv]
// ----------------------------------------------------------------------------
// lapic_in_stage
// Input register: holds one request until the timer logic consumes it.
// ----------------------------------------------------------------------------
module lapic_in_stage
    import lapic_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lapic_req_t s_req,
    input  logic       advance,
    output logic       req_valid,
    output lapic_req_t req
);

    logic       valid_reg;
    logic       valid_next;
    lapic_req_t req_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

[sv/lapic_timer_regs.sv]
// ----------------------------------------------------------------------------
// lapic_timer_regs
// Timer register file, prescaler and countdown; builds one response per
// request and commits the state when the request moves on.
// ----------------------------------------------------------------------------
module lapic_timer_regs
    import lapic_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  lapic_req_t req,
    output lapic_rsp_t rsp
);

    logic [7:0]             vector_reg,    vector_next;
    logic                   masked_reg,    masked_next;
    logic [1:0]             mode_reg,      mode_next;
    logic [COUNT_WIDTH-1:0] reload_reg,    reload_next;
    logic [COUNT_WIDTH-1:0] count_reg,     count_next;
    logic [3:0]             divide_reg,    divide_next;
    logic [PRESC_WIDTH-1:0] presc_reg,     presc_next;
    logic                   servicing_reg, servicing_next;

    logic [PERIOD_WIDTH-1:0] period;
    logic [PERIOD_WIDTH-1:0] presc_inc;
    logic [COUNT_WIDTH-1:0]  count_dec;
    logic                    step;

    assign period    = divide_period(divide_reg);
    assign presc_inc = {1'b0, presc_reg} + PERIOD_WIDTH'(1);
    assign step      = presc_inc >= period;
    assign count_dec = count_reg - COUNT_WIDTH'(1);

    always_comb begin
        vector_next    = vector_reg;
        masked_next    = masked_reg;
        mode_next      = mode_reg;
        reload_next    = reload_reg;
        count_next     = count_reg;
        divide_next    = divide_reg;
        presc_next     = presc_reg;
        servicing_next = servicing_reg;
        rsp            = '0;

        unique case (req.req_type)
            REQ_READ: begin
                unique case (req.reg_select)
                    SEL_LVT:       rsp.read_data = {13'd0, mode_reg, masked_reg, 8'd0,
                                                    vector_reg};
                    SEL_CUR_COUNT: rsp.read_data = 32'(count_reg);
                    SEL_DIVIDE:    rsp.read_data = {28'd0, divide_reg};
                    default:       rsp.read_data = '0;
                endcase
            end
            REQ_WRITE: begin
                unique case (req.reg_select)
                    SEL_LVT: begin
                        vector_next = req.write_data[7:0];
                        masked_next = |(req.write_data & LVT_MASK_BIT);
                        mode_next   = req.write_data[LVT_MODE_LSB +: 2];
                    end
                    SEL_INIT_COUNT: begin
                        reload_next = COUNT_WIDTH'(req.write_data);
                        count_next  = COUNT_WIDTH'(req.write_data);
                        presc_next  = '0;
                    end
                    SEL_DIVIDE: divide_next    = req.write_data[3:0] & DIV_KEEP_BITS;
                    SEL_EOI:    servicing_next = 1'b0;
                    default: ;
                endcase
            end
            REQ_TICK: begin
                presc_next = step ? '0 : presc_inc[PRESC_WIDTH-1:0];
                if (step && (count_reg != '0)) begin
                    count_next = count_dec;
                    if (count_dec == '0) begin
                        if (!masked_reg) begin
                            rsp.irq_fire   = 1'b1;
                            rsp.irq_vector = vector_reg;
                            servicing_next = 1'b1;
                        end
                        if (mode_reg == MODE_PERIODIC) begin
                            count_next = reload_reg;
                        end
                    end
                end
            end
            default: ;
        endcase

        rsp.in_service = servicing_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_reg    <= '0;
            masked_reg    <= 1'b1;
            mode_reg      <= '0;
            reload_reg    <= '0;
            count_reg     <= '0;
            divide_reg    <= '0;
            presc_reg     <= '0;
            servicing_reg <= 1'b0;
        end else if (advance) begin
            vector_reg    <= vector_next;
            masked_reg    <= masked_next;
            mode_reg      <= mode_next;
            reload_reg    <= reload_next;
            count_reg     <= count_next;
            divide_reg    <= divide_next;
            presc_reg     <= presc_next;
            servicing_reg <= servicing_next;
        end
    end

endmodule

[sv/lapic_out_stage.sv]
// ----------------------------------------------------------------------------
// lapic_out_stage
// Response register toward the result channel.
// ----------------------------------------------------------------------------
module lapic_out_stage
    import lapic_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rsp_valid,
    output logic       rsp_ready,
    input  lapic_rsp_t rsp,
    output logic       m_valid,
    input  logic       m_ready,
    output lapic_rsp_t m_rsp
);

    logic       valid_reg;
    logic       valid_next;
    lapic_rsp_t rsp_reg;

    assign rsp_ready  = !valid_reg || m_ready;
    assign valid_next = rsp_ready ? rsp_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            rsp_reg <= rsp;
        end
    end

    assign m_valid = valid_reg;
    assign m_rsp   = rsp_reg;

endmodule

[sv/lapic_checker.sv]
// ----------------------------------------------------------------------------
// lapic_checker
// Port-level checks on the local APIC timer core.
// ----------------------------------------------------------------------------
module lapic_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data,
    input logic        m_irq_fire,
    input logic [7:0]  m_irq_vector,
    input logic        m_in_service
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_irq_fire)
            && $stable(m_irq_vector) && $stable(m_in_service))
        else $error("response changed while stalled");

    // no vector without an interrupt
    a_vec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_irq_fire |-> m_irq_vector == 8'd0)
        else $error("vector without interrupt");

    // a delivered interrupt is in service
    a_fire_service: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_irq_fire |-> m_in_service)
        else $error("interrupt delivered without in-service");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid after reset");

endmodule

bind local_apic_timer_core lapic_checker u_lapic_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_irq_fire   (m_irq_fire),
    .m_irq_vector (m_irq_vector),
    .m_in_service (m_in_service)
);
